// ===== src/ccsp_pkg.sv =====
// shared types, widths and character codes for the cigar clip and span parser
// used by ccsp_accum, ccsp_result and cigar_clip_span_parser
// no dependencies
`timescale 1ns / 1ps

package ccsp_pkg;

	// operation length width, valid range 8 to 32
	localparam int OP_LEN_BITS = 31;

	localparam int CHAR_W  = 8;
	localparam int START_W = 31;
	localparam int SPAN_W  = 32;
	localparam int CLIP_W  = 31;
	localparam int QLEN_W  = 32;
	localparam int REND_W  = 34;
	localparam int QPOS_W  = 33;
	localparam int ERR_W   = 3;

	// largest clip value that fits the output field
	localparam logic [QPOS_W-1:0] CLIP_MAX = {{(QPOS_W-CLIP_W){1'b0}}, {CLIP_W{1'b1}}};

	// input word layout
	localparam int IN_CHAR_LO   = 0;
	localparam int IN_START_LO  = IN_CHAR_LO + CHAR_W;
	localparam int IN_TDATA_W   = 40;

	// output word layout
	localparam int OUT_LC_LO    = 0;
	localparam int OUT_RC_LO    = OUT_LC_LO + CLIP_W;
	localparam int OUT_QLEN_LO  = OUT_RC_LO + CLIP_W;
	localparam int OUT_REND_LO  = OUT_QLEN_LO + QLEN_W;
	localparam int OUT_QS_LO    = OUT_REND_LO + REND_W;
	localparam int OUT_QE_LO    = OUT_QS_LO + QPOS_W;
	localparam int OUT_ERR_LO   = OUT_QE_LO + QPOS_W;
	localparam int OUT_USED_W   = OUT_ERR_LO + ERR_W;
	localparam int OUT_TDATA_W  = 200;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
	localparam logic [CHAR_W-1:0] CH_I = 8'h49;
	localparam logic [CHAR_W-1:0] CH_D = 8'h44;
	localparam logic [CHAR_W-1:0] CH_S = 8'h53;
	localparam logic [CHAR_W-1:0] CH_H = 8'h48;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 3'd0,
		ERR_BAD   = 3'd1,
		ERR_NOLEN = 3'd2,
		ERR_NOOPS = 3'd3,
		ERR_OVF   = 3'd4
	} err_t;

	// one input character with its side fields
	typedef struct packed {
		logic [CHAR_W-1:0]  cigar_char;
		logic               is_last;
		logic [START_W-1:0] ref_start;
		logic               minus_strand;
	} in_t;

	// record totals captured on the last character
	typedef struct packed {
		logic [OP_LEN_BITS-1:0] first_clip;
		logic [OP_LEN_BITS-1:0] last_clip;
		logic [SPAN_W-1:0]      ref_span;
		logic [SPAN_W-1:0]      query_span;
		err_t                   err;
		logic                   seen_op;
		logic [START_W-1:0]     ref_start;
		logic                   minus_strand;
	} snap_t;

	// partial results between the two finishing stages
	typedef struct packed {
		logic [CLIP_W-1:0] left_clip;
		logic [CLIP_W-1:0] right_clip;
		logic [SPAN_W-1:0] part_len;
		logic [REND_W-1:0] ref_end;
		err_t              err;
		logic              minus_strand;
	} part_t;

	// accumulator status for checks
	typedef struct packed {
		logic s1_valid;
		logic s1_fire;
		logic s1_last;
		logic state_clear;
	} acc_stat_t;

	// keep the first error of a record
	function automatic err_t err_raise(err_t cur, err_t code);
		return (cur == ERR_NONE) ? code : cur;
	endfunction

endpackage

// ===== src/ccsp_accum.sv =====
// input register and per-character accumulator of the cigar parser
// builds op lengths, spans, clips and first error; snapshots totals on the last character
// depends on ccsp_pkg
`timescale 1ns / 1ps

module ccsp_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ccsp_pkg::in_t       in_item,
	output logic                snap_valid,
	input  logic                snap_ready,
	output ccsp_pkg::snap_t     snap,
	output ccsp_pkg::acc_stat_t stat
);

	logic              s1_valid_q;
	ccsp_pkg::in_t     item_s1;
	logic              s1_fire;
	logic              s2_free;
	logic              snap_valid_q;
	ccsp_pkg::snap_t   snap_s2;
	ccsp_pkg::snap_t   snap_d;

	logic [ccsp_pkg::OP_LEN_BITS-1:0] accum_q, accum_d;
	logic                             have_q, have_d;
	logic                             seen_q, seen_d;
	logic [ccsp_pkg::OP_LEN_BITS-1:0] first_q, first_d;
	logic [ccsp_pkg::OP_LEN_BITS-1:0] last_q, last_d;
	logic [ccsp_pkg::SPAN_W-1:0]      rspan_q, rspan_d;
	logic [ccsp_pkg::SPAN_W-1:0]      qspan_q, qspan_d;
	ccsp_pkg::err_t                   err_q, err_d;

	// stage handshakes
	assign s2_free  = !snap_valid_q || snap_ready;
	assign s1_fire  = s1_valid_q && (!item_s1.is_last || s2_free);
	assign in_ready = !s1_valid_q || s1_fire;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// character decode and state update
	always_comb begin
		logic [ccsp_pkg::OP_LEN_BITS+3:0] prod;
		logic [ccsp_pkg::OP_LEN_BITS-1:0] len;
		logic [ccsp_pkg::OP_LEN_BITS-1:0] clip;
		logic [ccsp_pkg::SPAN_W:0]        rsum;
		logic [ccsp_pkg::SPAN_W:0]        qsum;
		logic [ccsp_pkg::SPAN_W:0]        len_x;
		logic                             is_digit;
		logic                             is_upper;

		accum_d = accum_q;
		have_d  = have_q;
		seen_d  = seen_q;
		first_d = first_q;
		last_d  = last_q;
		rspan_d = rspan_q;
		qspan_d = qspan_q;
		err_d   = err_q;

		is_digit = (item_s1.cigar_char >= ccsp_pkg::CH_0) && (item_s1.cigar_char <= ccsp_pkg::CH_9);
		is_upper = (item_s1.cigar_char >= ccsp_pkg::CH_A) && (item_s1.cigar_char <= ccsp_pkg::CH_Z);

		// times ten as two shifts, plus the digit value
		prod = ({4'b0000, accum_q} << 3) + ({4'b0000, accum_q} << 1)
			+ {{ccsp_pkg::OP_LEN_BITS{1'b0}}, item_s1.cigar_char[3:0]};
		len   = have_q ? accum_q : '0;
		len_x = {{(ccsp_pkg::SPAN_W+1-ccsp_pkg::OP_LEN_BITS){1'b0}}, len};
		rsum  = {1'b0, rspan_q} + len_x;
		qsum  = {1'b0, qspan_q} + len_x;
		clip  = '0;

		if (is_digit) begin
			have_d = 1'b1;
			if (prod[ccsp_pkg::OP_LEN_BITS+3:ccsp_pkg::OP_LEN_BITS] != 4'd0) begin
				accum_d = '1;
				err_d   = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_OVF);
			end else begin
				accum_d = prod[ccsp_pkg::OP_LEN_BITS-1:0];
			end
		end else if (is_upper) begin
			if (!have_q) begin
				err_d = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_NOLEN);
			end
			unique case (item_s1.cigar_char)
				ccsp_pkg::CH_M: begin
					if (rsum[ccsp_pkg::SPAN_W]) begin
						rspan_d = '1;
						err_d   = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_OVF);
					end else begin
						rspan_d = rsum[ccsp_pkg::SPAN_W-1:0];
					end
					if (qsum[ccsp_pkg::SPAN_W]) begin
						qspan_d = '1;
						err_d   = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_OVF);
					end else begin
						qspan_d = qsum[ccsp_pkg::SPAN_W-1:0];
					end
				end
				ccsp_pkg::CH_I: begin
					if (qsum[ccsp_pkg::SPAN_W]) begin
						qspan_d = '1;
						err_d   = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_OVF);
					end else begin
						qspan_d = qsum[ccsp_pkg::SPAN_W-1:0];
					end
				end
				ccsp_pkg::CH_D: begin
					if (rsum[ccsp_pkg::SPAN_W]) begin
						rspan_d = '1;
						err_d   = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_OVF);
					end else begin
						rspan_d = rsum[ccsp_pkg::SPAN_W-1:0];
					end
				end
				ccsp_pkg::CH_S, ccsp_pkg::CH_H: begin
					clip = len;
				end
				default: begin
					err_d = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_BAD);
				end
			endcase
			if (!seen_q) begin
				first_d = clip;
			end
			last_d  = clip;
			seen_d  = 1'b1;
			accum_d = '0;
			have_d  = 1'b0;
		end else begin
			err_d = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_BAD);
		end

		snap_d.first_clip   = first_d;
		snap_d.last_clip    = last_d;
		snap_d.ref_span     = rspan_d;
		snap_d.query_span   = qspan_d;
		snap_d.err          = err_d;
		snap_d.seen_op      = seen_d;
		snap_d.ref_start    = item_s1.ref_start;
		snap_d.minus_strand = item_s1.minus_strand;
	end

	// record state, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			have_q  <= 1'b0;
			seen_q  <= 1'b0;
			first_q <= '0;
			last_q  <= '0;
			rspan_q <= '0;
			qspan_q <= '0;
			err_q   <= ccsp_pkg::ERR_NONE;
		end else if (s1_fire) begin
			if (item_s1.is_last) begin
				accum_q <= '0;
				have_q  <= 1'b0;
				seen_q  <= 1'b0;
				first_q <= '0;
				last_q  <= '0;
				rspan_q <= '0;
				qspan_q <= '0;
				err_q   <= ccsp_pkg::ERR_NONE;
			end else begin
				accum_q <= accum_d;
				have_q  <= have_d;
				seen_q  <= seen_d;
				first_q <= first_d;
				last_q  <= last_d;
				rspan_q <= rspan_d;
				qspan_q <= qspan_d;
				err_q   <= err_d;
			end
		end
	end

	// snapshot register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
		end else if (s2_free) begin
			snap_valid_q <= s1_fire && item_s1.is_last;
		end
	end

	// snapshot register payload
	always_ff @(posedge clk) begin
		if (s2_free && s1_fire && item_s1.is_last) begin
			snap_s2 <= snap_d;
		end
	end

	assign snap_valid = snap_valid_q;
	assign snap       = snap_s2;

	// status for checks
	assign stat.s1_valid    = s1_valid_q;
	assign stat.s1_fire     = s1_fire;
	assign stat.s1_last     = item_s1.is_last;
	assign stat.state_clear = (accum_q == '0) && !have_q && !seen_q && (first_q == '0)
		&& (last_q == '0) && (rspan_q == '0) && (qspan_q == '0)
		&& (err_q == ccsp_pkg::ERR_NONE);

endmodule

// ===== src/ccsp_result.sv =====
// two finishing stages of the cigar parser: clips, reference end, query length and positions
// ends in the output register that drives the result stream
// depends on ccsp_pkg
`timescale 1ns / 1ps

module ccsp_result (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 snap_valid,
	output logic                                 snap_ready,
	input  ccsp_pkg::snap_t                      snap,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ccsp_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	logic                             s3_valid_q;
	ccsp_pkg::part_t                  part_s3;
	ccsp_pkg::part_t                  part_d;
	logic                             out_valid_q;
	logic                             out_free;
	logic                             s3_free;

	logic [ccsp_pkg::CLIP_W-1:0]      lc_q, rc_q;
	logic [ccsp_pkg::QLEN_W-1:0]      qlen_q, qlen_d;
	logic [ccsp_pkg::REND_W-1:0]      rend_q;
	logic [ccsp_pkg::QPOS_W-1:0]      qs_q, qs_d;
	logic [ccsp_pkg::QPOS_W-1:0]      qe_q, qe_d;
	ccsp_pkg::err_t                   err_q, err_d;

	assign out_free   = !out_valid_q || m_tready;
	assign s3_free    = !s3_valid_q || out_free;
	assign snap_ready = s3_free;

	// clip saturation, first partial length, reference end, error so far
	always_comb begin
		logic [ccsp_pkg::QPOS_W-1:0] lc_x;
		logic [ccsp_pkg::QPOS_W-1:0] rc_x;
		logic [ccsp_pkg::SPAN_W:0]   psum;
		logic                        lc_ovf;
		logic                        rc_ovf;

		lc_x   = {{(ccsp_pkg::QPOS_W-ccsp_pkg::OP_LEN_BITS){1'b0}}, snap.first_clip};
		rc_x   = {{(ccsp_pkg::QPOS_W-ccsp_pkg::OP_LEN_BITS){1'b0}}, snap.last_clip};
		lc_ovf = lc_x > ccsp_pkg::CLIP_MAX;
		rc_ovf = rc_x > ccsp_pkg::CLIP_MAX;

		part_d.left_clip  = lc_ovf ? '1 : lc_x[ccsp_pkg::CLIP_W-1:0];
		part_d.right_clip = rc_ovf ? '1 : rc_x[ccsp_pkg::CLIP_W-1:0];

		psum = {2'b00, part_d.left_clip} + {1'b0, snap.query_span};
		part_d.part_len = psum[ccsp_pkg::SPAN_W] ? '1 : psum[ccsp_pkg::SPAN_W-1:0];

		part_d.ref_end = {3'b000, snap.ref_start} + {2'b00, snap.ref_span}
			- {{(ccsp_pkg::REND_W-1){1'b0}}, 1'b1};

		// no ops ranks before any overflow found here
		part_d.err = snap.err;
		if (!snap.seen_op) begin
			part_d.err = ccsp_pkg::err_raise(part_d.err, ccsp_pkg::ERR_NOOPS);
		end
		if (lc_ovf || rc_ovf || psum[ccsp_pkg::SPAN_W]) begin
			part_d.err = ccsp_pkg::err_raise(part_d.err, ccsp_pkg::ERR_OVF);
		end
		part_d.minus_strand = snap.minus_strand;
	end

	// partial stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (s3_free) begin
			s3_valid_q <= snap_valid;
		end
	end

	// partial stage payload
	always_ff @(posedge clk) begin
		if (s3_free && snap_valid) begin
			part_s3 <= part_d;
		end
	end

	// query length and strand-dependent query positions
	always_comb begin
		logic [ccsp_pkg::QLEN_W:0] qsum;

		qsum   = {1'b0, part_s3.part_len} + {2'b00, part_s3.right_clip};
		qlen_d = qsum[ccsp_pkg::QLEN_W] ? '1 : qsum[ccsp_pkg::QLEN_W-1:0];
		err_d  = part_s3.err;
		if (qsum[ccsp_pkg::QLEN_W]) begin
			err_d = ccsp_pkg::err_raise(err_d, ccsp_pkg::ERR_OVF);
		end
		if (part_s3.minus_strand) begin
			qs_d = {1'b0, qlen_d} - {2'b00, part_s3.left_clip};
			qe_d = {2'b00, part_s3.right_clip} + {{(ccsp_pkg::QPOS_W-1){1'b0}}, 1'b1};
		end else begin
			qs_d = {2'b00, part_s3.left_clip} + {{(ccsp_pkg::QPOS_W-1){1'b0}}, 1'b1};
			qe_d = {1'b0, qlen_d} - {2'b00, part_s3.right_clip};
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s3_valid_q;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && s3_valid_q) begin
			lc_q   <= part_s3.left_clip;
			rc_q   <= part_s3.right_clip;
			qlen_q <= qlen_d;
			rend_q <= part_s3.ref_end;
			qs_q   <= qs_d;
			qe_q   <= qe_d;
			err_q  <= err_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ccsp_pkg::OUT_TDATA_W-ccsp_pkg::OUT_USED_W){1'b0}},
		err_q, qe_q, qs_q, rend_q, qlen_q, rc_q, lc_q};

endmodule

// ===== src/cigar_clip_span_parser.sv =====
// cigar clip and span parser: one character word per cycle, one result word per record;
// the input stalls only while a last character waits on a full snapshot register
// reset: arst_n clears all valids and the record state; the block is ready right after
// depends on ccsp_pkg, ccsp_accum, ccsp_result
`timescale 1ns / 1ps

module cigar_clip_span_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// cigar_char [7:0], ref_start [38:8], zero pad [39]
	input  logic [ccsp_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                 s_tlast,
	// minus_strand
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// left_clip [30:0], right_clip [61:31], query_len [93:62], ref_end [127:94],
	// query_start [160:128], query_end [193:161], error_code [196:194], zero pad [199:197]
	output logic [ccsp_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	ccsp_pkg::in_t       in_item;
	ccsp_pkg::snap_t     snap;
	ccsp_pkg::acc_stat_t stat;
	logic                snap_valid;
	logic                snap_ready;

	// unpack the input word
	assign in_item.cigar_char   = s_tdata[ccsp_pkg::IN_CHAR_LO +: ccsp_pkg::CHAR_W];
	assign in_item.is_last      = s_tlast;
	assign in_item.ref_start    = s_tdata[ccsp_pkg::IN_START_LO +: ccsp_pkg::START_W];
	assign in_item.minus_strand = s_tuser;

	ccsp_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.stat       (stat)
	);

	ccsp_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

`ifndef SYNTHESIS
	// an empty input stage always takes a word
	assert property (@(posedge clk) disable iff (!arst_n)
		!stat.s1_valid |-> s_tready)
		else $error("input stage empty but not ready");

	// record state is cleared once the last character is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		(stat.s1_fire && stat.s1_last) |=> stat.state_clear)
		else $error("record state not cleared after last character");

	// a clean result never has a query length below its clips
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[ccsp_pkg::OUT_ERR_LO +: ccsp_pkg::ERR_W] == ccsp_pkg::ERR_NONE))
		|-> ({1'b0, m_tdata[ccsp_pkg::OUT_QLEN_LO +: ccsp_pkg::QLEN_W]}
			>= ({2'b00, m_tdata[ccsp_pkg::OUT_LC_LO +: ccsp_pkg::CLIP_W]}
			+ {2'b00, m_tdata[ccsp_pkg::OUT_RC_LO +: ccsp_pkg::CLIP_W]})))
		else $error("query length below clip sum without error");
`endif

endmodule
